@@ hw/rtl/blsp_pkg.sv @@
// Shared constants and request codes for the Bresenham line stepper.
// No dependencies; every other file of the block refers to this package.
package blsp_pkg;

  // Default coordinate width and the fixed color width.
  localparam int COORD_BITS_DEF = 12;
  localparam int COLOR_BITS     = 32;

  // Extra bits on top of the coordinate width for the decision terms.
  localparam int TERM_EXTRA = 3;

  // Depth of the command queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Request codes carried in req_type.
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

endpackage

@@ hw/rtl/blsp_ifs.sv @@
// Channel interfaces of the line stepper: request, command queue and pixel.
// Depends on blsp_pkg for the default widths.

// Request channel: start a line or ask for the next pixel.
interface blsp_req_if #(parameter int COORD_BITS = blsp_pkg::COORD_BITS_DEF);
  logic                              valid;
  logic                              ready;
  logic                              req_type;
  logic signed [COORD_BITS-1:0]      x_start;
  logic signed [COORD_BITS-1:0]      y_start;
  logic signed [COORD_BITS-1:0]      x_end;
  logic signed [COORD_BITS-1:0]      y_end;
  logic [blsp_pkg::COLOR_BITS-1:0]   line_color;

  modport source (output valid, req_type, x_start, y_start, x_end, y_end, line_color,
                  input ready);
  modport sink   (input valid, req_type, x_start, y_start, x_end, y_end, line_color,
                  output ready);
endinterface

// Pixel result channel.
interface blsp_pix_if #(parameter int COORD_BITS = blsp_pkg::COORD_BITS_DEF);
  logic                              valid;
  logic                              ready;
  logic signed [COORD_BITS-1:0]      pixel_x;
  logic signed [COORD_BITS-1:0]      pixel_y;
  logic [blsp_pkg::COLOR_BITS-1:0]   pixel_color;
  logic                              last_pixel;

  modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_color, last_pixel, output ready);
endinterface

// Classified command from the front to the back, through the queue.
interface blsp_cmd_if #(parameter int COORD_BITS = blsp_pkg::COORD_BITS_DEF);
  localparam int TW = COORD_BITS + blsp_pkg::TERM_EXTRA;
  logic                              valid;
  logic                              ready;
  logic                              is_start;
  logic signed [COORD_BITS-1:0]      cur_x;
  logic signed [COORD_BITS-1:0]      cur_y;
  logic signed [COORD_BITS-1:0]      stop_x;
  logic signed [COORD_BITS-1:0]      stop_y;
  logic signed [TW-1:0]              term;
  logic signed [TW-1:0]              stay_inc;
  logic signed [TW-1:0]              step_inc;
  logic                              steep;
  logic                              down;
  logic [blsp_pkg::COLOR_BITS-1:0]   color;

  modport source (output valid, is_start, cur_x, cur_y, stop_x, stop_y, term, stay_inc,
                  step_inc, steep, down, color, input ready);
  modport sink   (input valid, is_start, cur_x, cur_y, stop_x, stop_y, term, stay_inc,
                  step_inc, steep, down, color, output ready);
endinterface

@@ hw/rtl/blsp_front.sv @@
// Front of the line stepper: accepts request beats, orders the endpoints
// and sets up the Bresenham terms. Depends on blsp_pkg and blsp_ifs.
module blsp_front #(
  parameter int COORD_BITS = blsp_pkg::COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  blsp_req_if.sink    req,
  blsp_cmd_if.source  cmd
);

  localparam int DW = COORD_BITS + 1;
  localparam int TW = COORD_BITS + blsp_pkg::TERM_EXTRA;

  logic                             s1_valid_r;
  logic                             s1_type_r;
  logic signed [COORD_BITS-1:0]     s1_x0_r, s1_y0_r, s1_x1_r, s1_y1_r;
  logic signed [DW-1:0]             s1_dx_r, s1_dy_r;
  logic [blsp_pkg::COLOR_BITS-1:0]  s1_color_r;

  logic                             req_take;
  logic                             swap;
  logic signed [COORD_BITS-1:0]     x_lo, y_lo, x_hi, y_hi;
  logic signed [DW-1:0]             ady;
  logic                             down, steep;
  logic signed [TW-1:0]             dx_t, ady_t, dx2, ady2;

  // The stage takes a new beat when it is empty or its beat moves on.
  assign req.ready = !s1_valid_r || cmd.ready;
  assign req_take  = req.valid && req.ready;

  // Order by X; on a tie the second endpoint becomes the start.
  always_comb begin
    swap = !(req.x_start < req.x_end);
    x_lo = swap ? req.x_end   : req.x_start;
    y_lo = swap ? req.y_end   : req.y_start;
    x_hi = swap ? req.x_start : req.x_end;
    y_hi = swap ? req.y_start : req.y_end;
  end

  // First stage register: ordered endpoints and raw deltas.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (req_take) begin
      s1_valid_r <= 1'b1;
    end else if (cmd.ready) begin
      s1_valid_r <= 1'b0;
    end
    if (req_take) begin
      s1_type_r  <= req.req_type;
      s1_x0_r    <= x_lo;
      s1_y0_r    <= y_lo;
      s1_x1_r    <= x_hi;
      s1_y1_r    <= y_hi;
      s1_dx_r    <= DW'(x_hi) - DW'(x_lo);
      s1_dy_r    <= DW'(y_hi) - DW'(y_lo);
      s1_color_r <= req.line_color;
    end
  end

  // Direction, octant class and the decision terms.
  always_comb begin
    down  = s1_dy_r[DW-1];
    ady   = down ? -s1_dy_r : s1_dy_r;
    steep = !(s1_dx_r > ady);
    dx_t  = TW'(s1_dx_r);
    ady_t = TW'(ady);
    dx2   = {dx_t[TW-2:0], 1'b0};
    ady2  = {ady_t[TW-2:0], 1'b0};
  end

  assign cmd.valid    = s1_valid_r;
  assign cmd.is_start = (s1_type_r == blsp_pkg::REQ_START);
  assign cmd.cur_x    = s1_x0_r;
  assign cmd.cur_y    = s1_y0_r;
  assign cmd.stop_x   = s1_x1_r;
  assign cmd.stop_y   = s1_y1_r;
  assign cmd.term     = steep ? (ady_t - dx2) : (ady2 - dx_t);
  assign cmd.stay_inc = steep ? -dx2 : ady2;
  assign cmd.step_inc = ady2 - dx2;
  assign cmd.steep    = steep;
  assign cmd.down     = down;
  assign cmd.color    = s1_color_r;

endmodule

@@ hw/rtl/blsp_queue.sv @@
// Short command queue between the front and the back of the line stepper.
// Depends on blsp_pkg and blsp_ifs.
module blsp_queue #(
  parameter int COORD_BITS = blsp_pkg::COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  blsp_cmd_if.sink    enq,
  blsp_cmd_if.source  deq
);

  localparam int TW    = COORD_BITS + blsp_pkg::TERM_EXTRA;
  localparam int QW    = 1 + 4 * COORD_BITS + 3 * TW + 2 + blsp_pkg::COLOR_BITS;
  localparam int DEPTH = blsp_pkg::QUEUE_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  logic [QW-1:0]  mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  count_r;
  logic           push, pop;
  logic [QW-1:0]  wr_data, rd_data;

  assign enq.ready = (count_r != CW'(DEPTH));
  assign deq.valid = (count_r != '0);
  assign push      = enq.valid && enq.ready;
  assign pop       = deq.valid && deq.ready;

  assign wr_data = {enq.is_start, enq.cur_x, enq.cur_y, enq.stop_x, enq.stop_y, enq.term,
                    enq.stay_inc, enq.step_inc, enq.steep, enq.down, enq.color};
  assign rd_data = mem_r[rd_ptr_r];
  assign {deq.is_start, deq.cur_x, deq.cur_y, deq.stop_x, deq.stop_y, deq.term,
          deq.stay_inc, deq.step_inc, deq.steep, deq.down, deq.color} = rd_data;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

`ifndef SYNTHESIS
  // The fill count never exceeds the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH)) else $error("command queue count above depth");
  // With one entry and both sides moving, the count holds.
  a_count_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && pop) |=> (count_r == $past(count_r))) else $error("queue count drifted");
`endif

endmodule

@@ hw/rtl/blsp_back.sv @@
// Back of the line stepper: holds the line state, steps one pixel per step
// beat on an active line and drives the pixel output register. Depends on blsp_pkg, blsp_ifs.
module blsp_back #(
  parameter int COORD_BITS = blsp_pkg::COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  blsp_cmd_if.sink    cmd,
  blsp_pix_if.source  pix
);

  localparam int TW = COORD_BITS + blsp_pkg::TERM_EXTRA;

  logic                             active_r;
  logic                             steep_r, down_r;
  logic signed [COORD_BITS-1:0]     cur_x_r, cur_y_r, stop_x_r, stop_y_r;
  logic signed [TW-1:0]             term_r, stay_r, step_r;
  logic [blsp_pkg::COLOR_BITS-1:0]  color_r;

  logic                             out_valid_r;
  logic signed [COORD_BITS-1:0]     pix_x_r, pix_y_r;
  logic [blsp_pkg::COLOR_BITS-1:0]  pix_color_r;
  logic                             pix_last_r;

  logic                             out_free, pop, pix_load, last, take_stay;
  logic                             move_x, move_y;
  logic signed [COORD_BITS-1:0]     cur_x_nxt, cur_y_nxt;
  logic signed [TW-1:0]             term_nxt;

  // A start beat or an idle step always drains; a live step needs the output slot.
  assign out_free  = !out_valid_r || pix.ready;
  assign cmd.ready = cmd.is_start || !active_r || out_free;
  assign pop       = cmd.valid && cmd.ready;
  assign pix_load  = pop && !cmd.is_start && active_r;

  // One Bresenham step on the held terms.
  always_comb begin
    last      = steep_r ? (cur_y_r == stop_y_r) : (cur_x_r == stop_x_r);
    take_stay = steep_r ? !term_r[TW-1] : term_r[TW-1];
    move_x    = !steep_r || !take_stay;
    move_y    = steep_r || !take_stay;
    cur_x_nxt = move_x ? cur_x_r + COORD_BITS'(1) : cur_x_r;
    if (!move_y) begin
      cur_y_nxt = cur_y_r;
    end else if (down_r) begin
      cur_y_nxt = cur_y_r - COORD_BITS'(1);
    end else begin
      cur_y_nxt = cur_y_r + COORD_BITS'(1);
    end
    term_nxt  = term_r + (take_stay ? stay_r : step_r);
  end

  // Line state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (pop && cmd.is_start) begin
      active_r <= 1'b1;
    end else if (pix_load && last) begin
      active_r <= 1'b0;
    end
    if (pop && cmd.is_start) begin
      cur_x_r  <= cmd.cur_x;
      cur_y_r  <= cmd.cur_y;
      stop_x_r <= cmd.stop_x;
      stop_y_r <= cmd.stop_y;
      term_r   <= cmd.term;
      stay_r   <= cmd.stay_inc;
      step_r   <= cmd.step_inc;
      steep_r  <= cmd.steep;
      down_r   <= cmd.down;
      color_r  <= cmd.color;
    end else if (pix_load && !last) begin
      cur_x_r  <= cur_x_nxt;
      cur_y_r  <= cur_y_nxt;
      term_r   <= term_nxt;
    end
  end

  // Pixel output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pix_load) begin
      out_valid_r <= 1'b1;
    end else if (pix.ready) begin
      out_valid_r <= 1'b0;
    end
    if (pix_load) begin
      pix_x_r     <= cur_x_r;
      pix_y_r     <= cur_y_r;
      pix_color_r <= color_r;
      pix_last_r  <= last;
    end
  end

  assign pix.valid       = out_valid_r;
  assign pix.pixel_x     = pix_x_r;
  assign pix.pixel_y     = pix_y_r;
  assign pix.pixel_color = pix_color_r;
  assign pix.last_pixel  = pix_last_r;

`ifndef SYNTHESIS
  // A loaded start beat leaves a line active.
  a_start_active: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && cmd.is_start) |=> active_r) else $error("start did not activate line");
  // The last pixel ends the line.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (pix_load && last) |=> !active_r) else $error("line still active after last pixel");
  // Shallow lines advance X by one on every pixel before the last.
  a_shallow_x: assert property (@(posedge clk) disable iff (!rst_n)
    (pix_load && !last && !steep_r) |=> (cur_x_r == $past(cur_x_r) + COORD_BITS'(1)))
    else $error("shallow step did not advance X");
`endif

endmodule

@@ hw/rtl/bresenham_line_stepper_top.sv @@
// Bresenham line stepper, top level: front, command queue and back.
// Depends on blsp_pkg, blsp_ifs, blsp_front, blsp_queue and blsp_back.
//
// A start beat (req_type 0) orders the two endpoints by X, sets up the
// Bresenham terms and gives no pixel; each step beat (req_type 1) gives the
// next pixel of the line with its color and a last flag, and a step with no
// line loaded gives nothing. The block takes one request beat per clock,
// start or step, while the command queue has room, and gives one pixel per
// clock while the output is taken, set by the single add and compare of the
// back's step on its held terms. A step beat passes through the front setup
// stage register and the two-entry command queue before the back loads its
// pixel into the output register. Front and back stall on their own, so the
// output may be held for any time while request beats keep filling the queue.
module bresenham_line_stepper_top #(
  parameter int COORD_BITS = blsp_pkg::COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  blsp_req_if.sink    in_req,
  blsp_pix_if.source  out_pix
);

  blsp_cmd_if #(.COORD_BITS(COORD_BITS)) push_if ();
  blsp_cmd_if #(.COORD_BITS(COORD_BITS)) pop_if ();

  blsp_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (in_req),
    .cmd   (push_if)
  );

  blsp_queue #(.COORD_BITS(COORD_BITS)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .enq   (push_if),
    .deq   (pop_if)
  );

  blsp_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (pop_if),
    .pix   (out_pix)
  );

endmodule

@@ tb/sv/bresenham_line_stepper_top_tb.sv @@
// Self-checking testbench for the Bresenham line stepper top level.
// Depends on blsp_pkg, the blsp_ifs channel interfaces and bresenham_line_stepper_top.
`timescale 1ns / 100ps

module bresenham_line_stepper_top_tb;

  localparam int CB   = blsp_pkg::COORD_BITS_DEF;
  localparam int TW   = CB + blsp_pkg::TERM_EXTRA;
  localparam int CMIN = -(1 << (CB - 1));
  localparam int CMAX = (1 << (CB - 1)) - 1;

  localparam int RANDOM_ITEMS = 1050;
  localparam int TAIL_ITEMS   = 120;
  localparam int STALL_AFTER  = 400;
  localparam int STALL_CYCLES = 150;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct {
    logic                 req_type;
    logic signed [CB-1:0] xs;
    logic signed [CB-1:0] ys;
    logic signed [CB-1:0] xe;
    logic signed [CB-1:0] ye;
    logic [blsp_pkg::COLOR_BITS-1:0] color;
  } line_req_t;

  typedef struct {
    logic signed [CB-1:0]  x;
    logic signed [CB-1:0]  y;
    logic [blsp_pkg::COLOR_BITS-1:0] color;
    logic                  last;
  } pixel_t;

  logic clk;
  logic rst_n;

  blsp_req_if #(.COORD_BITS(CB)) req_bus ();
  blsp_pix_if #(.COORD_BITS(CB)) pix_bus ();

  bresenham_line_stepper_top #(.COORD_BITS(CB)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_bus),
    .out_pix (pix_bus)
  );

  line_req_t req_pending[$];
  pixel_t    pixels_due[$];

  int errors;
  int beats_taken;
  int cycles;
  int send_gap;
  int take_gap;
  int stall_left;
  bit stall_done;

  // Line state as the stepper should hold it.
  logic signed [CB-1:0]  ln_x, ln_y, ln_end_x, ln_end_y;
  logic signed [TW-1:0]  ln_term, ln_stay, ln_step;
  logic                  ln_steep, ln_down, ln_busy;
  logic [blsp_pkg::COLOR_BITS-1:0] ln_color;

  // Apply one accepted request beat to the line state; a step on an active
  // line appends the pixel it should produce.
  function automatic void apply_request(input line_req_t r);
    logic signed [TW-1:0] ax, ay, bx, by, dx, dy, ady;
    logic                 last;
    if (r.req_type == blsp_pkg::REQ_START) begin
      // Order by X; on a tie the second endpoint becomes the start.
      if (r.xs < r.xe) begin
        ln_x = r.xs; ln_y = r.ys; ln_end_x = r.xe; ln_end_y = r.ye;
      end else begin
        ln_x = r.xe; ln_y = r.ye; ln_end_x = r.xs; ln_end_y = r.ys;
      end
      ax = TW'(ln_x); ay = TW'(ln_y); bx = TW'(ln_end_x); by = TW'(ln_end_y);
      dx = bx - ax;
      dy = by - ay;
      ln_down  = (dy < 0);
      ady      = ln_down ? -dy : dy;
      ln_steep = !(dx > ady);
      if (!ln_steep) begin
        ln_term = TW'(2 * ady - dx);
        ln_stay = TW'(2 * ady);
      end else begin
        ln_term = TW'(ady - 2 * dx);
        ln_stay = TW'(-2 * dx);
      end
      ln_step  = TW'(2 * (ady - dx));
      ln_color = r.color;
      ln_busy  = 1'b1;
      return;
    end
    if (!ln_busy) return;
    last = ln_steep ? (ln_y == ln_end_y) : (ln_x == ln_end_x);
    pixels_due.push_back('{x: ln_x, y: ln_y, color: ln_color, last: last});
    if (last) begin
      ln_busy = 1'b0;
      return;
    end
    if (!ln_steep) begin
      // Shallow: X always advances, Y moves when the term is not negative.
      if (ln_term < 0) begin
        ln_term = ln_term + ln_stay;
      end else begin
        ln_y    = ln_down ? ln_y - CB'(1) : ln_y + CB'(1);
        ln_term = ln_term + ln_step;
      end
      ln_x = ln_x + CB'(1);
    end else begin
      // Steep: Y always moves, X advances when the term is negative.
      if (ln_term >= 0) begin
        ln_term = ln_term + ln_stay;
      end else begin
        ln_x    = ln_x + CB'(1);
        ln_term = ln_term + ln_step;
      end
      ln_y = ln_down ? ln_y - CB'(1) : ln_y + CB'(1);
    end
  endfunction

  function automatic int pick_delta();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 90) return int'($urandom_range(0, 24)) - 12;
    if (roll < 98) return int'($urandom_range(0, 120)) - 60;
    return int'($urandom_range(0, 800)) - 400;
  endfunction

  function automatic int clamp_coord(input int v);
    if (v < CMIN) return CMIN;
    if (v > CMAX) return CMAX;
    return v;
  endfunction

  function automatic int abs_int(input int v);
    return (v < 0) ? -v : v;
  endfunction

  task automatic queue_start(input int xs, input int ys, input int xe, input int ye,
                             input logic [blsp_pkg::COLOR_BITS-1:0] color);
    line_req_t r;
    r.req_type = blsp_pkg::REQ_START;
    r.xs = CB'(xs); r.ys = CB'(ys); r.xe = CB'(xe); r.ye = CB'(ye);
    r.color = color;
    req_pending.push_back(r);
  endtask

  // Step beats carry random payload, which the block must ignore.
  task automatic queue_steps(input int n);
    line_req_t r;
    repeat (n) begin
      r.req_type = blsp_pkg::REQ_STEP;
      r.xs = CB'($urandom); r.ys = CB'($urandom); r.xe = CB'($urandom); r.ye = CB'($urandom);
      r.color = $urandom;
      req_pending.push_back(r);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Cycle limit for the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("bresenham_line_stepper_top_tb NOT OK");
      $finish;
    end
  end

  // Request driver: offers the head of the pending queue and holds it until
  // the beat is taken.
  always @(posedge clk) begin : req_driver
    logic drive_now;
    logic held;
    if (!rst_n) begin
      req_bus.valid <= 1'b0;
      send_gap      <= 0;
    end else begin
      drive_now = 1'b0;
      held      = 1'b0;
      if (req_bus.valid && req_bus.ready) begin
        apply_request(req_pending.pop_front());
        beats_taken <= beats_taken + 1;
      end else begin
        held = req_bus.valid;
      end
      if (held) begin
        drive_now = 1'b1;
      end else if (send_gap != 0) begin
        send_gap <= send_gap - 1;
      end else if (req_pending.size() != 0) begin
        if (req_pending.size() >= TAIL_ITEMS && stall_left == 0 &&
            $urandom_range(0, 7) == 0) begin
          send_gap <= $urandom_range(0, 4);
        end else begin
          drive_now = 1'b1;
        end
      end
      req_bus.valid <= drive_now;
      if (drive_now && !held) begin
        req_bus.req_type   <= req_pending[0].req_type;
        req_bus.x_start    <= req_pending[0].xs;
        req_bus.y_start    <= req_pending[0].ys;
        req_bus.x_end      <= req_pending[0].xe;
        req_bus.y_end      <= req_pending[0].ye;
        req_bus.line_color <= req_pending[0].color;
      end
    end
  end

  // Long output hold-off, once, so the queue fills and the input stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left <= 0;
      stall_done <= 1'b0;
    end else if (!stall_done && beats_taken >= STALL_AFTER) begin
      stall_left <= STALL_CYCLES;
      stall_done <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // Pixel monitor: checks each pixel beat against the oldest expected pixel.
  always @(posedge clk) begin : pix_monitor
    pixel_t want;
    logic   rdy;
    if (!rst_n) begin
      pix_bus.ready <= 1'b0;
      take_gap      <= 0;
    end else begin
      if (pix_bus.valid && pix_bus.ready) begin
        if (pixels_due.size() == 0) begin
          $error("pixel beat with nothing expected: x=%0d y=%0d",
                 pix_bus.pixel_x, pix_bus.pixel_y);
          errors++;
        end else begin
          want = pixels_due.pop_front();
          if (pix_bus.pixel_x !== want.x) begin
            $error("pixel_x expected %0d got %0d", want.x, pix_bus.pixel_x);
            errors++;
          end
          if (pix_bus.pixel_y !== want.y) begin
            $error("pixel_y expected %0d got %0d", want.y, pix_bus.pixel_y);
            errors++;
          end
          if (pix_bus.pixel_color !== want.color) begin
            $error("pixel_color expected %h got %h", want.color, pix_bus.pixel_color);
            errors++;
          end
          if (pix_bus.last_pixel !== want.last) begin
            $error("last_pixel expected %0b got %0b", want.last, pix_bus.last_pixel);
            errors++;
          end
        end
      end
      if (stall_left != 0) begin
        rdy = 1'b0;
      end else if (take_gap != 0) begin
        take_gap <= take_gap - 1;
        rdy = 1'b0;
      end else if (req_pending.size() >= TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
        take_gap <= $urandom_range(0, 4);
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      pix_bus.ready <= rdy;
    end
  end

  initial begin : main
    int counted, x0, y0, x1, y1, span, kind, n;
    rst_n              = 1'b0;
    req_bus.valid      = 1'b0;
    req_bus.req_type   = blsp_pkg::REQ_STEP;
    req_bus.x_start    = '0;
    req_bus.y_start    = '0;
    req_bus.x_end      = '0;
    req_bus.y_end      = '0;
    req_bus.line_color = '0;
    pix_bus.ready      = 1'b0;
    errors      = 0;
    beats_taken = 0;
    cycles      = 0;
    ln_x = '0; ln_y = '0; ln_end_x = '0; ln_end_y = '0;
    ln_term = '0; ln_stay = '0; ln_step = '0;
    ln_steep = 1'b0; ln_down = 1'b0; ln_busy = 1'b0;
    ln_color = '0;

    // Directed lines. A step right after reset has no line to walk.
    queue_steps(1);
    // Single point at a corner; the second step finds the block idle.
    queue_start(CMIN, CMAX, CMIN, CMAX, 32'h0000_0000);
    queue_steps(2);
    // Horizontal line along the bottom edge.
    queue_start(CMAX - 3, CMIN, CMAX, CMIN, 32'h0000_00FF);
    queue_steps(4);
    // Steep downward line; its end pixel must be included.
    queue_start(CMIN, CMAX, CMIN + 1, CMAX - 3, 32'hFFFF_FFFF);
    queue_steps(4);
    // Tie in X: the second endpoint starts; cut short by the next start.
    queue_start(5, -3, 5, 2, 32'hA5A5_5A5A);
    queue_steps(3);
    // Full-range diagonal, dropped after two pixels.
    queue_start(CMIN, CMIN, CMAX, CMAX, 32'h8000_0001);
    queue_steps(2);
    // Endpoints given in reverse order, then one step past the end.
    queue_start(-4, 2, -8, 0, 32'h1234_5678);
    queue_steps(6);

    // Random lines: mostly complete, some with idle steps after the end,
    // some cut short by the next start, and stray steps.
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      x0 = int'($urandom_range(0, (1 << CB) - 1)) + CMIN;
      y0 = int'($urandom_range(0, (1 << CB) - 1)) + CMIN;
      x1 = clamp_coord(x0 + pick_delta());
      y1 = clamp_coord(y0 + pick_delta());
      span = abs_int(x1 - x0);
      if (abs_int(y1 - y0) > span) span = abs_int(y1 - y0);
      span = span + 1;
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        queue_steps(1);
      end else begin
        if (kind == 1) n = $urandom_range(0, span - 1);
        else if (kind < 6) n = span + $urandom_range(1, 2);
        else n = span;
        queue_start(x0, y0, x1, y1, $urandom);
        queue_steps(n);
        counted += 1 + ((n < span) ? n : span);
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (req_pending.size() != 0) @(posedge clk);
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("bresenham_line_stepper_top_tb OK");
    end else begin
      $display("bresenham_line_stepper_top_tb NOT OK");
    end
    $finish;
  end

endmodule
